>>> hdl/gibl_pkg.sv
// Shared types, sizes and helper functions for the grid index to box lookup.
// Used by every module of the block but gibl_ram; depends on nothing else.
package gibl_pkg;

  // Largest number of intervals on any axis.
  localparam int MAX_INTERVALS = 16;

  // Breakpoint list depth per axis and the index widths that follow from it.
  localparam int BP_DEPTH = MAX_INTERVALS + 1;
  localparam int CNT_W    = $clog2(BP_DEPTH);
  localparam int POS_W    = CNT_W + 1;
  localparam int HINT_W   = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

  // Cell record store.
  localparam int CELLS   = MAX_INTERVALS * MAX_INTERVALS * MAX_INTERVALS;
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  // Width of one configuration register.
  localparam int CFG_W = 5;

  localparam int NUM_AXES = 3;

  // Request command codes.
  typedef enum logic [1:0] {
    CMD_LOAD_BREAK = 2'd0,
    CMD_LOAD_REC   = 2'd1,
    CMD_LOOKUP     = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FOUND   = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_INTERVALS_X = 2'd0,
    CFG_INTERVALS_Y = 2'd1,
    CFG_INTERVALS_Z = 2'd2
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_DOWN,
    S_UP,
    S_CHECK,
    S_READ
  } state_e;

  // One request.
  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         axis;
    logic [4:0]         slot;
    logic signed [31:0] break_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] rec_offset;
    logic [15:0]        rec_ni;
    logic [15:0]        rec_nj;
    logic               rec_present;
  } gibl_req_t;

  // One result.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_offset;
    logic [15:0]        found_ni;
    logic [15:0]        found_nj;
  } gibl_res_t;

  // Extent part of a cell record.
  typedef struct packed {
    logic        present;
    logic [15:0] ni;
    logic [15:0] nj;
  } cell_ext_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic store;
    logic walk_down;
    logic walk_up;
    logic commit;
    logic push_load;
    logic push_outside;
    logic push_cell;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic stepping;
    logic in_range;
    logic res_free;
  } dp_status_t;

  // Control of one axis walker.
  typedef struct packed {
    logic start;
    logic walk_down;
    logic walk_up;
    logic commit;
  } axis_ctl_t;

  // Linear cell address of interval triple (i, j, k).
  function automatic logic [CELL_AW-1:0] cell_addr(input logic [HINT_W-1:0] i,
                                                   input logic [HINT_W-1:0] j,
                                                   input logic [HINT_W-1:0] k);
    logic [CELL_AW-1:0] a;
    a = CELL_AW'(k) * CELL_AW'(MAX_INTERVALS) + CELL_AW'(j);
    a = a * CELL_AW'(MAX_INTERVALS) + CELL_AW'(i);
    return a;
  endfunction

endpackage

>>> hdl/gibl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module gibl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/gibl_axis.sv
// Breakpoint list, walk position and hint of one axis.
// Depends on gibl_pkg.
module gibl_axis
  import gibl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               bp_we,
  input  logic [CNT_W-1:0]   bp_slot,
  input  logic signed [31:0] bp_value,
  input  logic [CNT_W-1:0]   size,
  input  logic signed [31:0] target,
  input  axis_ctl_t          ctl,
  output logic               step,
  output logic               in_range,
  output logic [HINT_W-1:0]  pos_idx
);

  logic signed [31:0]      bp [BP_DEPTH];
  logic signed [POS_W-1:0] pos;
  logic signed [POS_W-1:0] pos_next;
  logic [HINT_W-1:0]       hint;
  logic signed [POS_W-1:0] rd_pos;
  logic [CNT_W-1:0]        rd_idx;
  logic signed [31:0]      bp_rd;
  logic signed [POS_W-1:0] size_s;
  logic                    down_ok;
  logic                    up_ok;

  // Breakpoint store.
  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp[bp_slot] <= bp_value;
    end
  end

  // The down walk looks at the current breakpoint, the up walk at the next one.
  assign rd_pos  = ctl.walk_up ? pos + POS_W'(1) : pos;
  assign rd_idx  = rd_pos[CNT_W-1:0];
  assign bp_rd   = bp[rd_idx];
  assign size_s  = $signed({1'b0, size});

  assign down_ok  = !pos[POS_W-1] && (target < bp_rd);
  assign up_ok    = (pos < size_s) && (target >= bp_rd);
  assign step     = (ctl.walk_up && up_ok) || (ctl.walk_down && down_ok);
  assign in_range = !pos[POS_W-1] && (pos < size_s);
  assign pos_idx  = pos[HINT_W-1:0];

  // Next walk position.
  always_comb begin
    pos_next = pos;
    if (ctl.start) begin
      pos_next = $signed(POS_W'(hint));
    end else if (ctl.walk_down && down_ok) begin
      pos_next = pos - POS_W'(1);
    end else if (ctl.walk_up && up_ok) begin
      pos_next = pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      hint <= '0;
    end else begin
      pos <= pos_next;
      if (ctl.commit) begin
        hint <= pos[HINT_W-1:0];
      end
    end
  end

endmodule

>>> hdl/gibl_ctrl.sv
// Controller state machine: sequences clearing, loads, the walk and the cell read.
// Depends on gibl_pkg.
module gibl_ctrl
  import gibl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_command,
  input  dp_status_t status,
  output logic       req_stall,
  output dp_cmd_t    cmd
);

  state_e state;
  state_e state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = (req_command == CMD_LOOKUP) ? S_DOWN : S_LOAD;
        end
      end
      S_LOAD: begin
        if (status.res_free) begin
          cmd.store     = 1'b1;
          cmd.push_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DOWN: begin
        cmd.walk_down = 1'b1;
        if (!status.stepping) begin
          state_next = S_UP;
        end
      end
      S_UP: begin
        cmd.walk_up = 1'b1;
        if (!status.stepping) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.in_range) begin
          cmd.commit = 1'b1;
          state_next = S_READ;
        end else if (status.res_free) begin
          cmd.push_outside = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_READ: begin
        if (status.res_free) begin
          cmd.push_cell = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/gibl_datapath.sv
// Datapath: request register, interval counts, three axis walkers, cell record
// memories and the result register. Depends on gibl_pkg, gibl_axis and gibl_ram.
module gibl_datapath
  import gibl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  gibl_req_t        req,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  output logic             res_valid,
  input  logic             res_stall,
  output gibl_res_t        res
);

  gibl_req_t          item;
  logic [CNT_W-1:0]   size [NUM_AXES];
  logic [CNT_W-1:0]   cfg_size;
  logic signed [31:0] target [NUM_AXES];
  logic [NUM_AXES-1:0] ax_step;
  logic [NUM_AXES-1:0] ax_inside;
  logic [HINT_W-1:0]  ax_pos [NUM_AXES];
  axis_ctl_t          ax_ctl;
  logic               bp_slot_ok;
  logic               rec_ok;
  logic               rec_we;
  logic [CELL_AW-1:0] clr_addr;
  logic [CELL_AW-1:0] ext_waddr;
  cell_ext_t          ext_wdata;
  logic               ext_we;
  logic [CELL_AW-1:0] rd_addr;
  logic [CELL_AW-1:0] rec_addr;
  logic [31:0]        off_rdata;
  cell_ext_t          ext_rdata;
  gibl_res_t          res_next;

  // Interval count registers, clamped to the table size on write.
  assign cfg_size = (int'(cfg_data) > MAX_INTERVALS) ? CNT_W'(MAX_INTERVALS)
                                                     : CNT_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        size[a] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_INTERVALS_X: size[0] <= cfg_size;
        CFG_INTERVALS_Y: size[1] <= cfg_size;
        CFG_INTERVALS_Z: size[2] <= cfg_size;
        default: ;
      endcase
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req;
    end
  end

  assign target[0] = item.coord_x;
  assign target[1] = item.coord_y;
  assign target[2] = item.coord_z;

  assign ax_ctl.start     = cmd.capture;
  assign ax_ctl.walk_down = cmd.walk_down;
  assign ax_ctl.walk_up   = cmd.walk_up;
  assign ax_ctl.commit    = cmd.commit;

  assign bp_slot_ok = (int'(item.slot) <= MAX_INTERVALS);

  // One walker per axis.
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    logic bp_we;
    assign bp_we = cmd.store && (item.command == CMD_LOAD_BREAK)
                   && (item.axis == 2'(g)) && bp_slot_ok;
    gibl_axis u_axis (
      .clk      (clk),
      .rst      (rst),
      .bp_we    (bp_we),
      .bp_slot  (CNT_W'(item.slot)),
      .bp_value (item.break_value),
      .size     (size[g]),
      .target   (target[g]),
      .ctl      (ax_ctl),
      .step     (ax_step[g]),
      .in_range (ax_inside[g]),
      .pos_idx  (ax_pos[g])
    );
  end

  // Record load target check and address.
  assign rec_ok = ($unsigned(item.coord_x) < 32'(MAX_INTERVALS))
               && ($unsigned(item.coord_y) < 32'(MAX_INTERVALS))
               && ($unsigned(item.coord_z) < 32'(MAX_INTERVALS));
  assign rec_we   = cmd.store && (item.command == CMD_LOAD_REC) && rec_ok;
  assign rec_addr = cell_addr(item.coord_x[HINT_W-1:0], item.coord_y[HINT_W-1:0],
                              item.coord_z[HINT_W-1:0]);
  assign rd_addr  = cell_addr(ax_pos[0], ax_pos[1], ax_pos[2]);

  // Clearing pass over the extent memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + CELL_AW'(1);
    end
  end

  assign ext_we    = cmd.clear_step || rec_we;
  assign ext_waddr = cmd.clear_step ? clr_addr : rec_addr;
  always_comb begin
    ext_wdata = '0;
    if (!cmd.clear_step) begin
      ext_wdata.present = item.rec_present;
      ext_wdata.ni      = item.rec_ni;
      ext_wdata.nj      = item.rec_nj;
    end
  end

  gibl_ram #(.WIDTH(32), .DEPTH(CELLS)) u_offsets (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_addr),
    .wdata (item.rec_offset),
    .re    (cmd.commit),
    .raddr (rd_addr),
    .rdata (off_rdata)
  );

  gibl_ram #(.WIDTH($bits(cell_ext_t)), .DEPTH(CELLS)) u_extents (
    .clk   (clk),
    .we    (ext_we),
    .waddr (ext_waddr),
    .wdata (ext_wdata),
    .re    (cmd.commit),
    .raddr (rd_addr),
    .rdata (ext_rdata)
  );

  // Status back to the controller.
  assign status.clear_last = (clr_addr == CELL_AW'(CELLS - 1));
  assign status.stepping   = |ax_step;
  assign status.in_range   = &ax_inside;
  assign status.res_free   = !res_valid || !res_stall;

  // Result selection.
  always_comb begin
    res_next        = '0;
    res_next.status = ST_DONE;
    if (cmd.push_outside) begin
      res_next.status = ST_OUTSIDE;
    end else if (cmd.push_cell) begin
      if (ext_rdata.present) begin
        res_next.status       = ST_FOUND;
        res_next.found_offset = $signed(off_rdata);
        res_next.found_ni     = ext_rdata.ni;
        res_next.found_nj     = ext_rdata.nj;
      end else begin
        res_next.status = ST_EMPTY;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.push_load || cmd.push_outside || cmd.push_cell) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_load || cmd.push_outside || cmd.push_cell) begin
      res <= res_next;
    end
  end

endmodule

>>> hdl/grid_index_to_box_lookup.sv
// Top level of the grid index to box lookup: controller plus datapath.
// Depends on gibl_pkg, gibl_ctrl and gibl_datapath.
//
// Each request gives exactly one result. After reset the block clears all CELLS
// entries (4096 with 16 intervals per axis) of the cell extent memory,
// one entry per cycle, and holds req_stall high meanwhile; configuration
// writes are taken throughout. A lookup walks every axis down and then up
// from its hint: every axis compares one breakpoint per cycle in parallel,
// and the cell record comes from a memory with a registered read. A lookup
// that lands outside the table skips the cell read. A finished result waits
// in an output register while the next request is accepted.
module grid_index_to_box_lookup
  import gibl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  gibl_req_t        req,
  output logic             res_valid,
  input  logic             res_stall,
  output gibl_res_t        res
);

  dp_cmd_t    cmd;
  dp_status_t status;

  gibl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .status      (status),
    .req_stall   (req_stall),
    .cmd         (cmd)
  );

  gibl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

`ifndef SYNTHESIS
  // Only one request is in work at a time.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while another is in work");

  // A result is never pushed over one that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.push_load || cmd.push_outside || cmd.push_cell) |-> (!res_valid || !res_stall))
    else $error("result register overwritten");

  // Only a found record carries nonzero record fields.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status != ST_FOUND)) |->
      ((res.found_offset == 0) && (res.found_ni == 0) && (res.found_nj == 0)))
    else $error("record fields set on a result that is not found");

  // The walk only moves while the controller is walking.
  assert property (@(posedge clk) disable iff (rst)
    status.stepping |-> (cmd.walk_down || cmd.walk_up))
    else $error("axis stepped outside a walk");
`endif

endmodule
